// ===== rtl/ple_pkg.sv =====
// Package for the piecewise linear evaluator: types, codes and constants.
`default_nettype none
package ple_pkg;
  localparam int unsigned MaxKnots = 64;
  localparam int unsigned IdxW = $clog2(MaxKnots);
  localparam int unsigned CntW = $clog2(MaxKnots + 1);

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_EVAL   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_FULL     = 2'd2,
    ST_ZERO_SEG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_CLOSED = 2'd0,
    REG_START  = 2'd1,
    REG_END    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] position;
    logic signed [31:0] knot_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_word_t;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/piecewise_linear_evaluator.sv =====
// Top level of the piecewise linear evaluator: knot store and sequencer.
// Clear and append words go from decode straight to the output register. An
// evaluate word reads the knot memories for the clamp, the bisection and the
// segment ends, then starts the serial slope divider and waits on it. It then
// runs the split 34x48 multiply, the final add and the output register.
// The block takes no new word until the result word has been taken.
// Knot memories have one read port.
`default_nettype none
module piecewise_linear_evaluator import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CMD   = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_CAP   = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_DWAIT = 11'b00000100000,
    S_MUL0  = 11'b00001000000,
    S_MUL1  = 11'b00010000000,
    S_FIN   = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_e;

  // Read purposes; the evaluate walk uses P_VAL0, P_LAST, P_MID, P_SEGI and P_SEGN in that order.
  typedef enum logic [2:0] {
    P_FIRST = 3'd0, P_LAST = 3'd1, P_VAL0 = 3'd2, P_LO = 3'd3,
    P_MID = 3'd4, P_SEGI = 3'd5, P_SEGN = 3'd6
  } purp_e;

  state_e state_q, state_d;
  purp_e  purp_q, purp_d;
  logic [CntW-1:0] count_q, count_d;
  logic closed_q; logic signed [31:0] rstart_q, rend_q;
  in_word_t in_q;
  out_word_t res_q, res_d;

  logic [31:0] mem_pos [MaxKnots];
  logic [31:0] mem_val [MaxKnots];
  logic [31:0] rpos_q, rval_q;
  logic [IdxW-1:0] raddr;
  logic [CntW-1:0] cntm1;
  logic mem_we;
  logic is_close;

  logic [CntW:0] size_q, size_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, pidx_q, pidx_d;
  logic signed [32:0] t_q, t_d, p0_q, p0_d, ti_q, ti_d;
  logic signed [32:0] v0_q, v0_d, vi_q, vi_d;
  logic signed [33:0] dt_q, dt_d, dv_q, dv_d;
  logic [47:0] slope_q, slope_d;
  logic [95:0] prod_q, prod_d;
  logic [33:0] offm_q, offm_d;
  logic neg_q, neg_d;
  logic signed [32:0] ppos, pval;
  div_req_t dreq; div_rsp_t drsp;

  ple_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0; rstart_q <= '0; rend_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CLOSED: closed_q <= cfg_data_i[0];
        REG_START:  rstart_q <= cfg_data_i;
        REG_END:    rend_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The closing point with an unset range takes its position from the last stored knot.
  assign is_close = pidx_q >= {1'b0, count_q};
  assign cntm1 = count_q - 1'b1;
  assign mem_we = (state_q == S_CMD) && (in_q.func == FUNC_APPEND)
                  && (count_q < CntW'(MaxKnots));
  assign raddr = is_close ? cntm1[IdxW-1:0] : pidx_q[IdxW-1:0];
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_pos[count_q[IdxW-1:0]] <= in_q.position;
      mem_val[count_q[IdxW-1:0]] <= in_q.knot_value;
    end
    rpos_q <= mem_pos[raddr];
    rval_q <= mem_val[raddr];
  end

  // Point position/value; the closing point sits past the stored knots.
  always_comb begin
    if (!is_close) ppos = {rpos_q[31], rpos_q};
    else if (rstart_q != rend_q) ppos = {rend_q[31], rend_q};
    else ppos = {rpos_q[31], rpos_q} + 33'sd65536;
    pval = is_close ? v0_q : {rval_q[31], rval_q};
  end

  logic [33:0] dtm, dvm, offa;
  logic signed [33:0] off;
  logic [95:0] pm;
  logic [127:0] qraw;
  logic [79:0] qv;
  logic signed [42:0] sumv;
  assign dtm = dt_q[33] ? 34'(-dt_q) : dt_q;
  assign dvm = dv_q[33] ? 34'(-dv_q) : dv_q;
  assign off = {t_q[32], t_q} - {ti_q[32], ti_q};
  assign offa = off[33] ? 34'(-off) : off;

  always_comb begin
    state_d = state_q; purp_d = purp_q; count_d = count_q; res_d = res_q;
    size_d = size_q; lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; pidx_d = pidx_q;
    t_d = t_q; p0_d = p0_q; ti_d = ti_q; v0_d = v0_q; vi_d = vi_q;
    dt_d = dt_q; dv_d = dv_q; slope_d = slope_q; prod_d = prod_q;
    offm_d = offm_q; neg_d = neg_q;
    dreq = '0; pm = '0; qraw = '0; qv = '0; sumv = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CMD;
      S_CMD: begin
        res_d = '{result_value: '0, status: ST_OK};
        state_d = S_OUT;
        case (in_q.func)
          FUNC_CLEAR: count_d = '0;
          FUNC_APPEND:
            if (count_q < CntW'(MaxKnots)) count_d = count_q + 1'b1;
            else res_d.status = ST_FULL;
          FUNC_EVAL:
            if (count_q < CntW'(2)) res_d.status = ST_FEW;
            else begin
              size_d = {1'b0, count_q} + (CntW+1)'(closed_q);
              t_d = {in_q.position[31], in_q.position};
              pidx_d = '0; purp_d = P_VAL0; state_d = S_RD;
            end
          default: ;
        endcase
      end
      S_RD: state_d = S_CAP;
      S_CAP: begin
        state_d = S_RD;
        unique case (purp_q)
          P_VAL0: begin
            v0_d = pval; p0_d = ppos;
            if (t_q < ppos) t_d = ppos;
            pidx_d = size_q - 1'b1; purp_d = P_LAST;
          end
          P_LAST: begin
            if (t_q > ppos) t_d = ppos;
            lo_d = '0;
            if (size_q <= 2) begin
              pidx_d = '0; purp_d = P_SEGI;
            end else begin
              hi_d = size_q - 1'b1;
              mid_d = size_q - 1'b1 - (size_q >> 1);
              pidx_d = size_q - 1'b1 - (size_q >> 1); purp_d = P_MID;
            end
          end
          P_MID: begin
            // lo position is always known: p0 at lo=0, else the point just compared.
            if (p0_q <= t_q && t_q <= ppos) hi_d = mid_q;
            else begin lo_d = mid_q; p0_d = ppos; end
            if (lo_d + 1'b1 == hi_d) begin
              pidx_d = lo_d; purp_d = P_SEGI;
            end else begin
              mid_d = lo_d + ((hi_d - lo_d) >> 1);
              pidx_d = lo_d + ((hi_d - lo_d) >> 1);
            end
          end
          P_SEGI: begin
            ti_d = ppos; vi_d = pval; pidx_d = pidx_q + 1'b1; purp_d = P_SEGN;
          end
          default: begin
            dt_d = {ppos[32], ppos} - {ti_q[32], ti_q};
            dv_d = {pval[32], pval} - {vi_q[32], vi_q};
            state_d = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (dt_q == '0) begin
          res_d = '{result_value: vi_q[31:0], status: ST_ZERO_SEG};
          state_d = S_OUT;
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = {dvm[31:0], 16'h0};
          dreq.divisor = dtm[32:0];
          offm_d = offa;
          neg_d = off[33] != (dv_q[33] != dt_q[33]);
          state_d = S_DWAIT;
        end
      end
      S_DWAIT: if (drsp.done) begin slope_d = drsp.quotient; state_d = S_MUL0; end
      S_MUL0: begin
        prod_d = {62'h0, offm_q} * {72'h0, slope_q[23:0]};
        state_d = S_MUL1;
      end
      S_MUL1: begin
        pm = {62'h0, offm_q} * {72'h0, slope_q[47:24]};
        prod_d = prod_q + (pm << 24);
        state_d = S_FIN;
      end
      S_FIN: begin
        res_d.status = ST_OK;
        qraw = {32'h0, prod_q} >> 16;
        qv = qraw[79:0] + ((neg_q && prod_q[15:0] != 16'h0) ? 80'd1 : 80'd0);
        if (offm_q == '0 || slope_q == '0) res_d.result_value = vi_q[31:0];
        else if (qv > 80'h100_0000_0000)
          res_d.result_value = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
        else begin
          sumv = neg_q ? {{10{vi_q[32]}}, vi_q} - 43'(qv[40:0])
                       : {{10{vi_q[32]}}, vi_q} + 43'(qv[40:0]);
          if (sumv > 43'sd2147483647) res_d.result_value = 32'h7fff_ffff;
          else if (sumv < -43'sd2147483648) res_d.result_value = 32'h8000_0000;
          else res_d.result_value = sumv[31:0];
        end
        state_d = S_OUT;
      end
      S_OUT: state_d = S_WAIT;
      S_WAIT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; purp_q <= P_FIRST;
    end else begin
      state_q <= state_d; count_q <= count_d; purp_q <= purp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_data_i;
    res_q <= res_d; size_q <= size_d; lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    pidx_q <= pidx_d; t_q <= t_d; p0_q <= p0_d; ti_q <= ti_d; v0_q <= v0_d;
    vi_q <= vi_d; dt_q <= dt_d; dv_q <= dv_d; slope_q <= slope_d; prod_q <= prod_d;
    offm_q <= offm_d; neg_q <= neg_d;
  end

  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = state_q == S_WAIT;
  assign out_data_o = res_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxKnots)) else $error("knot count overflow");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
endmodule
`default_nettype wire

// ===== rtl/ple_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module ple_div import ple_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [47:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[32:0], quo_q[47]} - {1'b0, den_q};
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; den_d = req_i.divisor;
      cnt_d = 6'd47; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], quo_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire
